@@ rtl/spherical_triangle_angle_core_assert.svh @@
// assertion macros used by the checker file
`ifndef SPHERICAL_TRIANGLE_ANGLE_CORE_ASSERT_SVH
`define SPHERICAL_TRIANGLE_ANGLE_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define STAC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STAC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/stac_pkg.sv @@
// types, constants and elaboration-time table functions for the angle core
package stac_pkg;

	localparam int IQ       = 30;
	localparam int FIELD_W  = 18;
	localparam int CW       = 34;
	localparam int MAX_ITER = 32;
	localparam int SQ_STEPS = 32;
	localparam int SQW      = 64;
	localparam int NW       = 31;

	localparam logic [63:0] PI_Q61    = 64'h6487ED5110B4611A;
	localparam logic [63:0] PI30      = (PI_Q61 + (64'd1 << 30)) >> 31;
	localparam logic [63:0] HALF_PI30 = (PI_Q61 + (64'd1 << 31)) >> 32;
	localparam logic [63:0] TWO_PI30  = (PI_Q61 + (64'd1 << 29)) >> 30;
	localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

	typedef logic signed [CW-1:0] cval_t;

	localparam cval_t PI_Z      = CW'(PI30);
	localparam cval_t HALF_PI_Z = CW'(HALF_PI30);
	localparam cval_t TWO_PI_Z  = CW'(TWO_PI30);

	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
		logic  flip;
	} rot_lane_t;

	typedef struct packed {
		logic spec;
		logic pi_sel;
		logic neg;
	} ctl_t;

	typedef struct packed {
		logic [SQW-1:0] v;
		logic [SQW-1:0] r;
		logic [NW-1:0]  n;
		ctl_t           ctl;
	} sq_t;

	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
		ctl_t  ctl;
	} vec_t;

	// shift-subtract division, used by the table functions
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem = rem - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] arg);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] bt;
		v = arg;
		r = '0;
		bt = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// atan(2^-i) in q30 from the alternating series in q61
	function automatic logic [63:0] atan_q30(input int i);
		logic [63:0] acc;
		logic [63:0] term;
		int e;
		acc = '0;
		if (i == 0) begin
			acc = PI_Q61 >> 2;
		end else begin
			for (int k = 0; k < 62; k++) begin
				e = 61 - i * (2 * k + 1);
				if (e >= 0) begin
					term = udiv64(64'd1 << e, 64'(2 * k + 1));
					if (k[0])
						acc = acc - term;
					else
						acc = acc + term;
				end
			end
		end
		return (acc + (64'd1 << 30)) >> 31;
	endfunction

	function automatic logic [63:0] gain_q30(input int iters);
		logic [63:0] g;
		logic [63:0] s;
		g = 64'd1 << 30;
		for (int i = 0; i < MAX_ITER; i++) begin
			if (i < iters) begin
				if (2 * i <= 60)
					s = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
				else
					s = 64'd1 << 30;
				g = (g * s + (64'd1 << 29)) >> 30;
			end
		end
		return g;
	endfunction

endpackage

@@ rtl/stac_if.sv @@
// handshake channels: side lengths in, angle out
interface stac_in_if;
	logic valid;
	logic ready;
	logic [stac_pkg::FIELD_W-1:0] side_a;
	logic [stac_pkg::FIELD_W-1:0] side_b;
	logic [stac_pkg::FIELD_W-1:0] side_c;
	modport source(output valid, output side_a, output side_b, output side_c, input ready);
	modport sink(input valid, input side_a, input side_b, input side_c, output ready);
endinterface

interface stac_out_if;
	logic valid;
	logic ready;
	logic [stac_pkg::FIELD_W-1:0] angle;
	logic degenerate;
	modport source(output valid, output angle, output degenerate, input ready);
	modport sink(input valid, input angle, input degenerate, output ready);
endinterface

@@ rtl/spherical_triangle_angle_core.sv @@
// a word passes RED modulo two pi cells, stage 1, the rotation cells, stages 2 to 7, the
// square root cells, the vectoring cells and stage 8; RED is the number of modulo two pi
// steps (1 for FRAC_BITS >= 15, else 16 - FRAC_BITS)
// throughput: one word per cycle; every stage holds its word until the next one frees
// reset clears only the stage valid bits; the angle tables and gain are constants
module spherical_triangle_angle_core #(
	parameter int FRAC_BITS  = 16,
	parameter int ITERATIONS = 18
) (
	input logic       clk,
	input logic       arst_n,
	stac_in_if.sink   req,
	stac_out_if.source rsp
);

	localparam int CW   = stac_pkg::CW;
	localparam int NW   = stac_pkg::NW;
	localparam int SHIN = stac_pkg::IQ - FRAC_BITS;
	localparam int VW   = stac_pkg::FIELD_W + SHIN;
	localparam int RW   = (VW > 33) ? VW : 33;
	localparam int RED  = (VW > 33) ? VW - 32 : 1;
	localparam int SHR  = stac_pkg::IQ - FRAC_BITS;
	localparam logic [CW-1:0] RND = (SHR > 0) ? CW'(64'd1 << (SHR - 1)) : '0;
	localparam stac_pkg::cval_t GAIN = CW'(stac_pkg::gain_q30(ITERATIONS));
	localparam stac_pkg::cval_t ONE_Z = CW'(64'd1 << stac_pkg::IQ);

	// modulo two pi chain
	logic               red_v [RED+1];
	logic               red_r [RED+1];
	logic [2:0][RW-1:0] red_d [RED+1];

	assign red_v[0]    = req.valid;
	assign red_d[0][0] = RW'(req.side_a) << SHIN;
	assign red_d[0][1] = RW'(req.side_b) << SHIN;
	assign red_d[0][2] = RW'(req.side_c) << SHIN;
	assign req.ready   = red_r[0];

	for (genvar g = 0; g < RED; g++) begin : g_red
		stac_red_cell #(.RW(RW), .SH(RED - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_valid(red_v[g]), .up_ready(red_r[g]), .up_data(red_d[g]),
			.dn_valid(red_v[g+1]), .dn_ready(red_r[g+1]), .dn_data(red_d[g+1])
		);
	end

	// stage 1: fold into [-pi/2, pi/2]
	logic                      v_s1;
	logic                      rdy_s1;
	stac_pkg::rot_lane_t [2:0] lane_s1;
	stac_pkg::rot_lane_t [2:0] fold;
	stac_pkg::cval_t           zf;

	logic                      rot_v [ITERATIONS+1];
	logic                      rot_r [ITERATIONS+1];
	stac_pkg::rot_lane_t [2:0] rot_d [ITERATIONS+1];

	assign rdy_s1       = !v_s1 || rot_r[0];
	assign red_r[RED]   = rdy_s1;

	always_comb begin
		zf = '0;
		for (int l = 0; l < 3; l++) begin
			zf = CW'(red_d[RED][l][32:0]);
			if (zf > stac_pkg::PI_Z)
				zf = zf - stac_pkg::TWO_PI_Z;
			fold[l].x = ONE_Z;
			fold[l].y = '0;
			fold[l].flip = 1'b0;
			if (zf > stac_pkg::HALF_PI_Z) begin
				zf = zf - stac_pkg::PI_Z;
				fold[l].flip = 1'b1;
			end else if (zf < -stac_pkg::HALF_PI_Z) begin
				zf = zf + stac_pkg::PI_Z;
				fold[l].flip = 1'b1;
			end
			fold[l].z = zf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= red_v[RED];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && red_v[RED]) begin
			lane_s1 <= fold;
		end
	end

	// sine and cosine rotation chain
	assign rot_v[0] = v_s1;
	assign rot_d[0] = lane_s1;

	for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
		stac_rot_cell #(.IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_valid(rot_v[g]), .up_ready(rot_r[g]), .up_data(rot_d[g]),
			.dn_valid(rot_v[g+1]), .dn_ready(rot_r[g+1]), .dn_data(rot_d[g+1])
		);
	end

	// stage 2: products
	logic                       v_s2;
	logic                       rdy_s2;
	logic signed [2*CW-1:0]     pgc_s2;
	logic signed [2*CW-1:0]     pab_s2;
	logic signed [2*CW-1:0]     pss_s2;
	stac_pkg::cval_t            ca;
	stac_pkg::cval_t            cb;
	stac_pkg::cval_t            cc;
	stac_pkg::cval_t            sa;
	stac_pkg::cval_t            sb;

	logic rdy_s3;

	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rot_r[ITERATIONS] = rdy_s2;

	// a fold by pi negates both sine and cosine
	assign ca = rot_d[ITERATIONS][0].flip ? -rot_d[ITERATIONS][0].x : rot_d[ITERATIONS][0].x;
	assign sa = rot_d[ITERATIONS][0].flip ? -rot_d[ITERATIONS][0].y : rot_d[ITERATIONS][0].y;
	assign cb = rot_d[ITERATIONS][1].flip ? -rot_d[ITERATIONS][1].x : rot_d[ITERATIONS][1].x;
	assign sb = rot_d[ITERATIONS][1].flip ? -rot_d[ITERATIONS][1].y : rot_d[ITERATIONS][1].y;
	assign cc = rot_d[ITERATIONS][2].flip ? -rot_d[ITERATIONS][2].x : rot_d[ITERATIONS][2].x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= rot_v[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && rot_v[ITERATIONS]) begin
			pgc_s2 <= GAIN * cc;
			pab_s2 <= ca * cb;
			pss_s2 <= sa * sb;
		end
	end

	// stage 3: numerator, denominator, special cases
	logic                 v_s3;
	logic [31:0]          n_s3;
	logic [31:0]          d_s3;
	stac_pkg::ctl_t       ctl_s3;
	logic signed [39:0]   num;
	logic signed [39:0]   den;
	logic [39:0]          n_abs;
	logic [39:0]          d_abs;
	stac_pkg::ctl_t       ctl_nd;

	logic rdy_s4;

	assign rdy_s3 = !v_s3 || rdy_s4;

	always_comb begin
		num = 40'(pgc_s2 >>> stac_pkg::IQ) - 40'(pab_s2 >>> stac_pkg::IQ);
		den = 40'(pss_s2 >>> stac_pkg::IQ);
		n_abs = num[39] ? 40'(-num) : 40'(num);
		d_abs = den[39] ? 40'(-den) : 40'(den);
		ctl_nd.neg = num[39] != den[39];
		ctl_nd.spec = (d_abs == '0) || (n_abs > d_abs);
		// ratio clamped to -1 gives pi, zero denominator gives zero
		ctl_nd.pi_sel = ctl_nd.neg && (d_abs != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			n_s3 <= n_abs[31:0];
			d_s3 <= d_abs[31:0];
			ctl_s3 <= ctl_nd;
		end
	end

	// stage 4: normalize, first half (right step, then left by 16 and 8)
	logic           v_s4;
	logic [NW-1:0]  n_s4;
	logic [NW-1:0]  d_s4;
	stac_pkg::ctl_t ctl_s4;
	logic [NW-1:0]  n_a;
	logic [NW-1:0]  d_a;

	logic rdy_s5;

	assign rdy_s4 = !v_s4 || rdy_s5;

	always_comb begin
		if (d_s3[31]) begin
			d_a = d_s3[31:1];
			n_a = n_s3[31:1];
		end else begin
			d_a = d_s3[NW-1:0];
			n_a = n_s3[NW-1:0];
		end
		if (d_a[30:15] == '0) begin
			d_a = d_a << 16;
			n_a = n_a << 16;
		end
		if (d_a[30:23] == '0) begin
			d_a = d_a << 8;
			n_a = n_a << 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			n_s4 <= n_a;
			d_s4 <= d_a;
			ctl_s4 <= ctl_s3;
		end
	end

	// stage 5: normalize, second half (left by 4, 2, 1)
	logic           v_s5;
	logic [NW-1:0]  n_s5;
	logic [NW-1:0]  d_s5;
	stac_pkg::ctl_t ctl_s5;
	logic [NW-1:0]  n_b;
	logic [NW-1:0]  d_b;

	logic rdy_s6;

	assign rdy_s5 = !v_s5 || rdy_s6;

	always_comb begin
		d_b = d_s4;
		n_b = n_s4;
		if (d_b[30:27] == '0) begin
			d_b = d_b << 4;
			n_b = n_b << 4;
		end
		if (d_b[30:29] == '0) begin
			d_b = d_b << 2;
			n_b = n_b << 2;
		end
		if (!d_b[30]) begin
			d_b = d_b << 1;
			n_b = n_b << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && v_s4) begin
			n_s5 <= n_b;
			d_s5 <= d_b;
			ctl_s5 <= ctl_s4;
		end
	end

	// stage 6: squares
	logic            v_s6;
	logic [2*NW-1:0] dd_s6;
	logic [2*NW-1:0] nn_s6;
	logic [NW-1:0]   n_s6;
	stac_pkg::ctl_t  ctl_s6;

	logic rdy_s7;

	assign rdy_s6 = !v_s6 || rdy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (rdy_s6) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s6 && v_s5) begin
			dd_s6 <= d_s5 * d_s5;
			nn_s6 <= n_s5 * n_s5;
			n_s6 <= n_s5;
			ctl_s6 <= ctl_s5;
		end
	end

	// stage 7: radicand for sqrt(d*d - n*n)
	logic          v_s7;
	stac_pkg::sq_t sq_s7;

	logic          sq_v [stac_pkg::SQ_STEPS+1];
	logic          sq_r [stac_pkg::SQ_STEPS+1];
	stac_pkg::sq_t sq_d [stac_pkg::SQ_STEPS+1];

	assign rdy_s7 = !v_s7 || sq_r[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (rdy_s7) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s7 && v_s6) begin
			sq_s7.v <= stac_pkg::SQW'(dd_s6 - nn_s6);
			sq_s7.r <= '0;
			sq_s7.n <= n_s6;
			sq_s7.ctl <= ctl_s6;
		end
	end

	// square root chain, one result bit per cell
	assign sq_v[0] = v_s7;
	assign sq_d[0] = sq_s7;

	for (genvar g = 0; g < stac_pkg::SQ_STEPS; g++) begin : g_sq
		stac_sqrt_cell #(.IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_valid(sq_v[g]), .up_ready(sq_r[g]), .up_data(sq_d[g]),
			.dn_valid(sq_v[g+1]), .dn_ready(sq_r[g+1]), .dn_data(sq_d[g+1])
		);
	end

	// vectoring chain: atan2(root, n)
	logic           vec_v [ITERATIONS+1];
	logic           vec_r [ITERATIONS+1];
	stac_pkg::vec_t vec_d [ITERATIONS+1];

	assign vec_v[0] = sq_v[stac_pkg::SQ_STEPS];
	assign sq_r[stac_pkg::SQ_STEPS] = vec_r[0];
	assign vec_d[0].x = CW'(sq_d[stac_pkg::SQ_STEPS].n);
	assign vec_d[0].y = CW'(sq_d[stac_pkg::SQ_STEPS].r[NW-1:0]);
	assign vec_d[0].z = '0;
	assign vec_d[0].ctl = sq_d[stac_pkg::SQ_STEPS].ctl;

	for (genvar g = 0; g < ITERATIONS; g++) begin : g_vec
		stac_vec_cell #(.IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.up_valid(vec_v[g]), .up_ready(vec_r[g]), .up_data(vec_d[g]),
			.dn_valid(vec_v[g+1]), .dn_ready(vec_r[g+1]), .dn_data(vec_d[g+1])
		);
	end

	// stage 8: clamp, reflect, round, saturate; this is the output register
	logic                        v_s8;
	logic                        rdy_s8;
	logic [stac_pkg::FIELD_W-1:0] angle_s8;
	logic                        deg_s8;
	stac_pkg::cval_t             zc;
	logic [CW-1:0]               res;
	logic [stac_pkg::FIELD_W-1:0] angle_nxt;

	assign rdy_s8 = !v_s8 || rsp.ready;
	assign vec_r[ITERATIONS] = rdy_s8;

	always_comb begin
		zc = vec_d[ITERATIONS].z;
		if (zc < 0)
			zc = '0;
		else if (zc > stac_pkg::HALF_PI_Z)
			zc = stac_pkg::HALF_PI_Z;
		if (vec_d[ITERATIONS].ctl.neg)
			zc = stac_pkg::PI_Z - zc;
		if (vec_d[ITERATIONS].ctl.spec)
			zc = vec_d[ITERATIONS].ctl.pi_sel ? stac_pkg::PI_Z : '0;
		res = (CW'(zc) + RND) >> SHR;
		if (res > CW'(stac_pkg::FIELD_MAX))
			angle_nxt = stac_pkg::FIELD_MAX;
		else
			angle_nxt = res[stac_pkg::FIELD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (rdy_s8) begin
			v_s8 <= vec_v[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s8 && vec_v[ITERATIONS]) begin
			angle_s8 <= angle_nxt;
			deg_s8 <= vec_d[ITERATIONS].ctl.spec;
		end
	end

	assign rsp.valid      = v_s8;
	assign rsp.angle      = angle_s8;
	assign rsp.degenerate = deg_s8;

endmodule

@@ rtl/stac_red_cell.sv @@
// one conditional-subtract step of the modulo two pi reduction, three lanes
module stac_red_cell #(
	parameter int RW = 33,
	parameter int SH = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic [2:0][RW-1:0] up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output logic [2:0][RW-1:0] dn_data
);

	localparam logic [RW-1:0] TP = RW'(stac_pkg::TWO_PI30) << SH;

	logic              valid_q;
	logic [2:0][RW-1:0] data_q;
	logic [2:0][RW-1:0] nxt;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (up_data[l] >= TP)
				nxt[l] = up_data[l] - TP;
			else
				nxt[l] = up_data[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

@@ rtl/stac_rot_cell.sv @@
// one rotation micro-step for the three sides
module stac_rot_cell #(
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  stac_pkg::rot_lane_t [2:0]   up_data,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output stac_pkg::rot_lane_t [2:0]   dn_data
);

	localparam stac_pkg::cval_t ATAN = stac_pkg::CW'(stac_pkg::atan_q30(IDX));

	logic                      valid_q;
	stac_pkg::rot_lane_t [2:0] data_q;
	stac_pkg::rot_lane_t [2:0] nxt;
	stac_pkg::cval_t           dx;
	stac_pkg::cval_t           dy;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		nxt = up_data;
		dx = '0;
		dy = '0;
		for (int l = 0; l < 3; l++) begin
			dx = up_data[l].y >>> IDX;
			dy = up_data[l].x >>> IDX;
			if (up_data[l].z >= 0) begin
				nxt[l].x = up_data[l].x - dx;
				nxt[l].y = up_data[l].y + dy;
				nxt[l].z = up_data[l].z - ATAN;
			end else begin
				nxt[l].x = up_data[l].x + dx;
				nxt[l].y = up_data[l].y - dy;
				nxt[l].z = up_data[l].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

@@ rtl/stac_sqrt_cell.sv @@
// one digit of the restoring square root
module stac_sqrt_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  stac_pkg::sq_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output stac_pkg::sq_t dn_data
);

	localparam logic [stac_pkg::SQW-1:0] BT = stac_pkg::SQW'(64'd1 << (62 - 2 * IDX));

	logic                    valid_q;
	stac_pkg::sq_t           data_q;
	stac_pkg::sq_t           nxt;
	logic [stac_pkg::SQW-1:0] trial;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		nxt = up_data;
		trial = up_data.r + BT;
		if (up_data.v >= trial) begin
			nxt.v = up_data.v - trial;
			nxt.r = (up_data.r >> 1) + BT;
		end else begin
			nxt.r = up_data.r >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

@@ rtl/stac_vec_cell.sv @@
// one vectoring micro-step of the arctangent
module stac_vec_cell #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  stac_pkg::vec_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output stac_pkg::vec_t dn_data
);

	localparam stac_pkg::cval_t ATAN = stac_pkg::CW'(stac_pkg::atan_q30(IDX));

	logic            valid_q;
	stac_pkg::vec_t  data_q;
	stac_pkg::vec_t  nxt;
	stac_pkg::cval_t dx;
	stac_pkg::cval_t dy;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_comb begin
		nxt = up_data;
		dx = up_data.y >>> IDX;
		dy = up_data.x >>> IDX;
		if (up_data.y >= 0) begin
			nxt.x = up_data.x + dx;
			nxt.y = up_data.y - dy;
			nxt.z = up_data.z + ATAN;
		end else begin
			nxt.x = up_data.x - dx;
			nxt.y = up_data.y + dy;
			nxt.z = up_data.z - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

@@ rtl/stac_checker.sv @@
// port-level checks for the angle core, bound to the top level
`include "spherical_triangle_angle_core_assert.svh"

module stac_checker #(
	parameter int FRAC_BITS = 16
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [stac_pkg::FIELD_W-1:0] angle,
	input logic                         degenerate
);

	localparam int SHR = stac_pkg::IQ - FRAC_BITS;
	localparam logic [63:0] RND = (SHR > 0) ? (64'd1 << (SHR - 1)) : 64'd0;
	localparam logic [63:0] PI_RND = (stac_pkg::PI30 + RND) >> SHR;
	localparam logic [stac_pkg::FIELD_W-1:0] AMAX =
		(PI_RND > 64'(stac_pkg::FIELD_MAX)) ? stac_pkg::FIELD_MAX : stac_pkg::FIELD_W'(PI_RND);

	// a word waiting at the output stays until taken, unchanged
	`STAC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")
	`STAC_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(angle) && $stable(degenerate), "result word changed while stalled")
	// a free or draining output stage frees every stage behind it
	`STAC_ASSERT_IMP(a_req_ready, !rsp_valid || rsp_ready, req_ready, "input stalled with a free output stage")
	// an interior angle never exceeds pi
	`STAC_ASSERT_IMP(a_angle_max, rsp_valid, angle <= AMAX, "angle above pi")

endmodule

bind spherical_triangle_angle_core stac_checker #(.FRAC_BITS(FRAC_BITS)) u_stac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.angle(rsp.angle),
	.degenerate(rsp.degenerate)
);

@@ sim/stac_tb_if.sv @@
// testbench-side note: channel interfaces come from the rtl file stac_if.sv
package stac_tb_pkg;
	localparam int LATENCY = 77;
endpackage

@@ sim/tb.sv @@
// testbench for the spherical triangle angle core: directed and random triangles against a fixed-point predictor
module tb;

	localparam int FRAC = 16;
	localparam int ITERS = 18;

	logic clk;
	logic arst_n;
	int errors;
	int sent;
	int send_idle_pct;
	int recv_stall_pct;
	bit long_hold;

	stac_in_if req ();
	stac_out_if rsp ();

	spherical_triangle_angle_core #(.FRAC_BITS(FRAC), .ITERATIONS(ITERS)) u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// angle predictor in q30, mirrors the fixed-point cordic data path
	class angle_scoreboard;
		longint atan_q[stac_pkg::MAX_ITER];
		longint gain;
		longint pending_angle[$];
		bit pending_flag[$];

		function new();
			longint g;
			for (int i = 0; i < stac_pkg::MAX_ITER; i++)
				atan_q[i] = longint'(stac_pkg::atan_q30(i));
			g = longint'(stac_pkg::gain_q30(ITERS));
			gain = g;
		endfunction

		function automatic longint fshr(longint v, int s);
			return v >>> s;
		endfunction

		function automatic void rotate(logic [stac_pkg::FIELD_W-1:0] side, output longint c,
				output longint s);
			longint z, x, y, dx, dy;
			bit flip;
			longint unsigned v;
			v = longint'(side) << (stac_pkg::IQ - FRAC);
			v = v % longint'(stac_pkg::TWO_PI30);
			z = longint'(v);
			x = longint'(1) << stac_pkg::IQ;
			y = 0;
			flip = 0;
			if (z > longint'(stac_pkg::PI30))
				z -= longint'(stac_pkg::TWO_PI30);
			if (z > longint'(stac_pkg::HALF_PI30)) begin
				z -= longint'(stac_pkg::PI30);
				flip = 1;
			end else if (z < -longint'(stac_pkg::HALF_PI30)) begin
				z += longint'(stac_pkg::PI30);
				flip = 1;
			end
			for (int i = 0; i < ITERS; i++) begin
				dx = fshr(y, i);
				dy = fshr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_q[i];
				end else begin
					x += dx; y -= dy; z += atan_q[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function automatic longint vector(longint x, longint y);
			longint z, dx, dy;
			z = 0;
			for (int i = 0; i < ITERS; i++) begin
				dx = fshr(y, i);
				dy = fshr(x, i);
				if (y >= 0) begin
					x += dx; y -= dy; z += atan_q[i];
				end else begin
					x -= dx; y += dy; z -= atan_q[i];
				end
			end
			if (z < 0)
				z = 0;
			if (z > longint'(stac_pkg::HALF_PI30))
				z = longint'(stac_pkg::HALF_PI30);
			return z;
		endfunction

		function void note_triangle(logic [stac_pkg::FIELD_W-1:0] a,
				logic [stac_pkg::FIELD_W-1:0] b, logic [stac_pkg::FIELD_W-1:0] c);
			longint ca, sa, cb, sb, cc, sc, num, den, z;
			longint unsigned n, d, yv, res;
			bit neg, flag;
			rotate(a, ca, sa);
			rotate(b, cb, sb);
			rotate(c, cc, sc);
			num = fshr(gain * cc, stac_pkg::IQ) - fshr(ca * cb, stac_pkg::IQ);
			den = fshr(sa * sb, stac_pkg::IQ);
			neg = (num < 0) != (den < 0);
			n = num < 0 ? -num : num;
			d = den < 0 ? -den : den;
			flag = 0;
			if (d == 0) begin
				z = 0;
				flag = 1;
			end else if (n > d) begin
				z = neg ? longint'(stac_pkg::PI30) : 0;
				flag = 1;
			end else begin
				while (d >= (64'd1 << 31)) begin
					d >>= 1;
					n >>= 1;
				end
				while (d < (64'd1 << 30)) begin
					d <<= 1;
					n <<= 1;
				end
				yv = stac_pkg::isqrt64(d * d - n * n);
				z = vector(longint'(n), longint'(yv));
				if (neg)
					z = longint'(stac_pkg::PI30) - z;
			end
			res = (longint'(z) + (64'd1 << (stac_pkg::IQ - FRAC - 1))) >> (stac_pkg::IQ - FRAC);
			if (res > longint'(stac_pkg::FIELD_MAX))
				res = stac_pkg::FIELD_MAX;
			pending_angle.push_back(longint'(res));
			pending_flag.push_back(flag);
		endfunction

		task check_angle(logic [stac_pkg::FIELD_W-1:0] angle, logic degenerate);
			if (pending_angle.size() == 0) begin
				report("unexpected word", angle, -1);
				return;
			end
			if (angle != pending_angle[0])
				report("angle", angle, pending_angle[0]);
			if (degenerate != pending_flag[0])
				report("degenerate", degenerate, pending_flag[0]);
			void'(pending_angle.pop_front());
			void'(pending_flag.pop_front());
		endtask
	endclass

	angle_scoreboard sb;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic send_triangle(input logic [stac_pkg::FIELD_W-1:0] a,
			input logic [stac_pkg::FIELD_W-1:0] b, input logic [stac_pkg::FIELD_W-1:0] c);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.side_a <= a;
		req.side_b <= b;
		req.side_c <= c;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_triangle(a, b, c);
		sent++;
	endtask

	function automatic logic [stac_pkg::FIELD_W-1:0] rand_side();
		case ($urandom_range(9))
			0: return '0;
			1: return stac_pkg::FIELD_W'(205887);
			2: return stac_pkg::FIELD_MAX;
			3: return stac_pkg::FIELD_W'($urandom_range(16));
			4: return stac_pkg::FIELD_W'(102944 + $urandom_range(8) - 4);
			default: return stac_pkg::FIELD_W'($urandom_range(205887));
		endcase
	endfunction

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_angle.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stall, or a long hold-off counted in cycles
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp.ready <= 1'b0;
				for (int i = 0; i < 400; i++)
					@(posedge clk);
				long_hold = 0;
			end
			rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_angle(rsp.angle, rsp.degenerate);

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [stac_pkg::FIELD_W-1:0] hpi;
		sb = new();
		errors = 0;
		sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold = 0;
		hpi = 102944;
		req.valid = 1'b0;
		req.side_a = '0;
		req.side_b = '0;
		req.side_c = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero sides, max field values, right angles, collinear and clamped ratios
		send_triangle(0, 0, 0);
		send_triangle(0, hpi, hpi);
		send_triangle(stac_pkg::FIELD_MAX, stac_pkg::FIELD_MAX, stac_pkg::FIELD_MAX);
		send_triangle(205887, 205887, 0);
		send_triangle(hpi, hpi, hpi);
		send_triangle(hpi, hpi, 205887);
		send_triangle(hpi, hpi, 0);
		send_triangle(65536, 65536, 0);
		send_triangle(65536, 65536, 131072);
		send_triangle(65536, 32768, 98304);
		send_triangle(65536, 32768, 16384);
		send_triangle(65536, 65536, 65536);
		send_triangle(1, 1, 1);
		send_triangle(1, 1, stac_pkg::FIELD_MAX);
		send_triangle(205887, hpi, hpi);
		send_triangle(18'h2AAAA, 18'h15555, 18'h3FFFF);
		send_triangle(18'h15555, 18'h2AAAA, 18'h00000);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 60; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 60; end
				3: begin send_idle_pct = 16; recv_stall_pct = 16; end
				4: begin send_idle_pct = 0; recv_stall_pct = 0; long_hold = 1; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			for (int i = 0; i < 240; i++)
				send_triangle(rand_side(), rand_side(), rand_side());
			// sender pauses until the pipeline is empty
			drain();
		end

		repeat (stac_tb_pkg::LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
